// ===== hw/rtl/qlfc_pkg.sv =====
package qlfc_pkg;

  localparam int SYM_W         = 8;
  localparam int COUNT_W       = 9;
  localparam int ALPHABET_SIZE = 256;

  // distinct count saturates here
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(9'h100);

  // token walks the list, one cell per advancing cycle
  typedef struct packed {
    logic             valid;
    logic             start;
    logic [SYM_W-1:0] sym;
    logic [SYM_W-1:0] carry;
    logic             carry_seen;
    logic             found;
    logic             is_new;
    logic [SYM_W-1:0] pos;
  } token_t;

endpackage

// ===== hw/rtl/qlfc_front.sv =====
module qlfc_front #(
  parameter int ALPHABET_SIZE = qlfc_pkg::ALPHABET_SIZE
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       advance,
  input  logic                       in_valid,
  input  logic [qlfc_pkg::SYM_W-1:0] in_symbol,
  input  logic                       in_block_start,
  output qlfc_pkg::token_t           tok_out
);

  localparam logic [qlfc_pkg::SYM_W:0] SYM_LIMIT = (qlfc_pkg::SYM_W+1)'(ALPHABET_SIZE);

  logic [qlfc_pkg::SYM_W-1:0] prev_r, prev_nxt;
  logic                       in_block_r, in_block_nxt;
  qlfc_pkg::token_t           tok_r, tok_nxt;
  logic                       accept;
  logic                       pass;

  assign accept = in_valid && advance;

  // drop out-of-alphabet symbols, items outside a block and repeats
  assign pass = ({1'b0, in_symbol} < SYM_LIMIT) &&
                (in_block_start || (in_block_r && (in_symbol != prev_r)));

  always_comb begin
    prev_nxt     = prev_r;
    in_block_nxt = in_block_r;
    tok_nxt      = tok_r;
    if (advance) begin
      tok_nxt            = '0;
      tok_nxt.sym        = in_symbol;
      tok_nxt.start      = in_block_start;
      tok_nxt.carry      = in_symbol;
      tok_nxt.carry_seen = 1'b1;
      tok_nxt.valid      = accept && pass;
      if (accept && pass) begin
        prev_nxt     = in_symbol;
        in_block_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r     <= '0;
      in_block_r <= 1'b0;
      tok_r      <= '0;
    end else begin
      prev_r     <= prev_nxt;
      in_block_r <= in_block_nxt;
      tok_r      <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

// ===== hw/rtl/qlfc_cell.sv =====
module qlfc_cell #(
  parameter int INDEX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  qlfc_pkg::token_t tok_in,
  output qlfc_pkg::token_t tok_out
);

  localparam logic [qlfc_pkg::SYM_W-1:0] IDX = qlfc_pkg::SYM_W'(INDEX);

  logic [qlfc_pkg::SYM_W-1:0] value_r, value_nxt;
  logic                       seen_r, seen_nxt;
  qlfc_pkg::token_t           tok_r, tok_nxt;
  logic [qlfc_pkg::SYM_W-1:0] init_val;
  logic [qlfc_pkg::SYM_W-1:0] held;
  logic                       held_seen;

  // identity entry, with entries 0 and 1 swapped when the block opens on 0
  assign init_val  = ((tok_in.sym == '0) && (INDEX < 2)) ? (IDX ^ qlfc_pkg::SYM_W'(1)) : IDX;
  assign held      = tok_in.start ? init_val : value_r;
  assign held_seen = tok_in.start ? 1'b0 : seen_r;

  always_comb begin
    value_nxt = value_r;
    seen_nxt  = seen_r;
    tok_nxt   = tok_r;
    if (advance) begin
      tok_nxt = tok_in;
      if (tok_in.valid) begin
        if (!tok_in.found) begin
          value_nxt = tok_in.carry;
          seen_nxt  = tok_in.carry_seen;
          if (held == tok_in.sym) begin
            tok_nxt.found  = 1'b1;
            tok_nxt.pos    = IDX;
            tok_nxt.is_new = !held_seen;
          end else begin
            tok_nxt.carry      = held;
            tok_nxt.carry_seen = held_seen;
          end
        end else begin
          value_nxt = held;
          seen_nxt  = held_seen;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_r <= IDX;
      seen_r  <= 1'b0;
      tok_r   <= '0;
    end else begin
      value_r <= value_nxt;
      seen_r  <= seen_nxt;
      tok_r   <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

// ===== hw/rtl/qlfc_move_to_front_coder.sv =====
// channel   ports                                   direction
// input     in_valid, in_ready, in_symbol,          in  (one byte per beat)
//           in_block_start
// result    out_valid, out_ready, out_code          out (zero or one beat per input)
//
// one beat accepted per cycle while in_ready is high; the output register holds the code
// the list is a chain of ALPHABET_SIZE cells; a byte walks it one cell per advancing cycle
// repeats, bytes outside a block and out-of-alphabet bytes are dropped at the front
// a stall on the result side freezes the whole chain and drops in_ready
// synchronous reset leaves the identity list, no block open, distinct count zero
module qlfc_move_to_front_coder #(
  parameter int ALPHABET_SIZE = qlfc_pkg::ALPHABET_SIZE
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [qlfc_pkg::SYM_W-1:0] in_symbol,
  input  logic                       in_block_start,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [qlfc_pkg::SYM_W-1:0] out_code
);

  qlfc_pkg::token_t tok [ALPHABET_SIZE+1];

  logic                         advance;
  logic                         out_valid_r, out_valid_nxt;
  logic [qlfc_pkg::SYM_W-1:0]   out_code_r, out_code_nxt;
  logic [qlfc_pkg::COUNT_W-1:0] count_r, count_nxt;
  qlfc_pkg::token_t             tail;

  // chain moves whenever the output register is free or being drained
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = advance;

  // filter and entry register
  qlfc_front #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .advance        (advance),
    .in_valid       (in_valid),
    .in_symbol      (in_symbol),
    .in_block_start (in_block_start),
    .tok_out        (tok[0])
  );

  // move-to-front list, cell i holds list entry i and its seen flag
  for (genvar i = 0; i < ALPHABET_SIZE; i++) begin : g_cell
    qlfc_cell #(
      .INDEX (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  assign tail = tok[ALPHABET_SIZE];

  // tail: tokens arrive in input order, so the distinct count lives here
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_code_nxt  = out_code_r;
    count_nxt     = count_r;
    if (advance) begin
      out_valid_nxt = tail.valid;
      if (tail.valid) begin
        if (tail.start) begin
          // block opener is always new and always codes as zero
          out_code_nxt = '0;
          count_nxt    = qlfc_pkg::COUNT_W'(1);
        end else if (tail.is_new) begin
          // first occurrence: distinct count minus one, wrapped to a byte
          out_code_nxt = count_r[qlfc_pkg::SYM_W-1:0] - qlfc_pkg::SYM_W'(1);
          if (count_r < qlfc_pkg::COUNT_LIMIT) begin
            count_nxt = count_r + qlfc_pkg::COUNT_W'(1);
          end
        end else begin
          // seen before: old list position minus one
          out_code_nxt = tail.pos - qlfc_pkg::SYM_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_code_r <= out_code_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_code  = out_code_r;

endmodule

// ===== test/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // number of cells in the chain plus one; sizes the hold-off and the final wait
  localparam int LATENCY     = qlfc_pkg::ALPHABET_SIZE + 1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_BEATS = 800;
  // receiver hold-off, long enough for the chain to fill and drop in_ready
  localparam int HOLD_CYCLES = 4 * LATENCY;
  localparam int HOLD_AFTER  = 200;

  typedef struct {
    logic [qlfc_pkg::SYM_W-1:0] sym;
    logic                       start;
    bit                         drain;   // wait for every code to come back first
  } byte_beat_t;

  logic                       clk;
  logic                       rst_n          = 1'b0;
  logic                       in_valid       = 1'b0;
  logic                       in_ready;
  logic [qlfc_pkg::SYM_W-1:0] in_symbol      = '0;
  logic                       in_block_start = 1'b0;
  logic                       out_valid;
  logic                       out_ready      = 1'b0;
  logic [qlfc_pkg::SYM_W-1:0] out_code;

  qlfc_move_to_front_coder uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_symbol      (in_symbol),
    .in_block_start (in_block_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code       (out_code)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predicted coder state
  // ---------------------------------------------------------------------------
  logic [qlfc_pkg::SYM_W-1:0]   mtf_order [qlfc_pkg::ALPHABET_SIZE];
  bit                           sym_seen  [qlfc_pkg::ALPHABET_SIZE];
  logic [qlfc_pkg::COUNT_W-1:0] distinct_n;
  logic [qlfc_pkg::SYM_W-1:0]   last_sym;
  bit                           block_open;

  byte_beat_t                 byte_q[$];        // bytes still to be offered
  logic [qlfc_pkg::SYM_W-1:0] pending_codes[$]; // codes predicted, not yet seen

  int beats_sent    = 0;
  int codes_checked = 0;
  int fails         = 0;
  int cycle_n       = 0;
  int blocks_n      = 0;
  int idle_left     = 0;
  int stall_left    = 0;
  int hold_left     = 0;
  bit hold_done     = 0;
  bit drain_done    = 0;

  // identity list, nothing seen, count zero
  function automatic void clear_list();
    for (int i = 0; i < qlfc_pkg::ALPHABET_SIZE; i++) begin
      mtf_order[i] = qlfc_pkg::SYM_W'(i);
      sym_seen[i]  = 1'b0;
    end
    distinct_n = '0;
  endfunction

  // advances the predicted list by one byte; returns 1 when a code comes out
  function automatic bit mtf_encode(input logic [qlfc_pkg::SYM_W-1:0] sym, input logic start,
                                    output logic [qlfc_pkg::SYM_W-1:0] code);
    int pos;
    bit hit;
    pos = 0;
    hit = 1'b0;
    code = '0;
    if (int'(sym) >= qlfc_pkg::ALPHABET_SIZE) return 1'b0;
    if (start) begin
      clear_list();
      // zero as the opening byte starts from a list with 0 and 1 swapped
      if (sym == '0) begin
        mtf_order[0] = 8'd1;
        mtf_order[1] = 8'd0;
      end
      block_open = 1'b1;
    end else begin
      if (!block_open) return 1'b0;
      if (sym == last_sym) return 1'b0;
    end
    for (int i = 0; i < qlfc_pkg::ALPHABET_SIZE; i++) begin
      if (!hit && mtf_order[i] == sym) begin
        pos = i;
        hit = 1'b1;
      end
    end
    for (int i = pos; i > 0; i--) mtf_order[i] = mtf_order[i-1];
    mtf_order[0] = sym;
    if (!sym_seen[sym]) begin
      // first time in this block: distinct count minus one, wrapped
      code = qlfc_pkg::SYM_W'(distinct_n - 1'b1);
      sym_seen[sym] = 1'b1;
      if (distinct_n < qlfc_pkg::COUNT_LIMIT) distinct_n = distinct_n + 1'b1;
    end else begin
      code = qlfc_pkg::SYM_W'(pos - 1);
    end
    if (start) code = '0;
    last_sym = sym;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers bytes from byte_q, predicts each accepted beat
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive
    logic [qlfc_pkg::SYM_W-1:0] c;
    byte_beat_t                 nxt;
    if (!rst_n) begin
      clear_list();
      last_sym   = '0;
      block_open = 1'b0;
      idle_left  = 0;
    end else begin
      if (in_valid && in_ready) begin
        if (mtf_encode(in_symbol, in_block_start, c)) pending_codes.push_back(c);
        beats_sent++;
        // every fourth stretch of 64 beats runs with no sender gaps
        idle_left = ((beats_sent / 64) % 4 == 3) ? 0 : $urandom_range(0, 3);
      end
      if (!in_valid || in_ready) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (byte_q.size() != 0 && !(byte_q[0].drain && pending_codes.size() != 0)) begin
          nxt = byte_q.pop_front();
          if (nxt.drain) drain_done = 1'b1;
          in_valid       <= 1'b1;
          in_symbol      <= nxt.sym;
          in_block_start <= nxt.start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compares each code beat with the oldest prediction, drives out_ready
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    logic [qlfc_pkg::SYM_W-1:0] want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        codes_checked++;
        if (pending_codes.size() == 0) begin
          $error("code: no code expected, actual %0d", out_code);
          fails++;
        end else begin
          want = pending_codes.pop_front();
          if (out_code !== want) begin
            $error("code: expected %0d, actual %0d", want, out_code);
            fails++;
          end
        end
        // some stretches take every beat at once
        stall_left = ((codes_checked / 50) % 4 == 2) ? 0 : $urandom_range(0, 3);
      end
      // one long hold-off while the sender keeps pushing, to back up the chain
      if (hold_left == 0 && !hold_done && beats_sent >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // runaway guard
  always @(posedge clk) begin
    cycle_n++;
    if (cycle_n > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d codes outstanding", cycle_n, pending_codes.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  logic [qlfc_pkg::SYM_W-1:0] gen_prev = '0;
  bit                         gen_open = 1'b0;
  int                         coded_n  = 0;

  // queues one byte and keeps track of how many of them will be coded
  task automatic queue_byte(input logic [qlfc_pkg::SYM_W-1:0] sym, input logic start,
                            input bit drain);
    byte_beat_t b;
    b.sym   = sym;
    b.start = start;
    b.drain = drain;
    byte_q.push_back(b);
    if (start || (gen_open && sym != gen_prev)) coded_n++;
    if (start) begin
      gen_open = 1'b1;
      blocks_n++;
    end
    if (start || gen_open) gen_prev = sym;
  endtask

  initial begin : run
    logic [qlfc_pkg::SYM_W-1:0] perm [qlfc_pkg::ALPHABET_SIZE];
    logic [qlfc_pkg::SYM_W-1:0] s;
    logic [qlfc_pkg::SYM_W-1:0] tmp;
    logic [qlfc_pkg::SYM_W-1:0] base;
    int  len;
    int  span;
    int  j;
    int  pick;
    bit  narrow;
    bit  perm_done;
    perm_done = 1'b0;

    // bytes before any block start are dropped
    queue_byte(8'h05, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);
    // zero opens the block: list starts with 0 and 1 swapped
    queue_byte(8'h00, 1'b1, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);   // repeat, no code
    queue_byte(8'h01, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(8'h01, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);   // repeat, no code
    queue_byte(8'hAA, 1'b0, 1'b0);
    queue_byte(8'h55, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    // block start equal to the byte before it still codes; sender drains first
    queue_byte(8'h00, 1'b1, 1'b1);
    queue_byte(8'hFF, 1'b1, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(8'h01, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);
    // back-to-back block starts
    queue_byte(8'h07, 1'b1, 1'b0);
    queue_byte(8'h07, 1'b1, 1'b0);
    queue_byte(8'h08, 1'b0, 1'b0);

    coded_n = 0;
    while (byte_q.size() < RANDOM_BEATS) begin
      pick = $urandom_range(0, 99);
      if (!perm_done && coded_n > 300) begin
        // one block holding every symbol: distinct count runs up to its limit
        for (int i = 0; i < qlfc_pkg::ALPHABET_SIZE; i++) perm[i] = qlfc_pkg::SYM_W'(i);
        for (int i = qlfc_pkg::ALPHABET_SIZE - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = perm[i];
          perm[i] = perm[j];
          perm[j] = tmp;
        end
        for (int i = 0; i < qlfc_pkg::ALPHABET_SIZE; i++) queue_byte(perm[i], i == 0, 1'b0);
        // the opening symbol now sits at the back of the list
        queue_byte(perm[0], 1'b0, 1'b0);
        perm_done = 1'b1;
      end else if (pick < 80) begin
        // well-formed block, often over a narrow alphabet so symbols recur
        len    = $urandom_range(1, 40);
        narrow = 1'($urandom_range(0, 1));
        base   = qlfc_pkg::SYM_W'($urandom_range(0, 255));
        span   = $urandom_range(2, 8);
        for (int k = 0; k < len; k++) begin
          if (k > 0 && $urandom_range(0, 4) == 0) s = gen_prev;
          else if (narrow) s = base + qlfc_pkg::SYM_W'($urandom_range(0, span - 1));
          else s = qlfc_pkg::SYM_W'($urandom_range(0, 255));
          queue_byte(s, k == 0, k == 0 && $urandom_range(0, 9) == 0);
        end
      end else begin
        // noise: random bytes with a stray block start now and then
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++)
          queue_byte(qlfc_pkg::SYM_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, 1'b0);
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_q.size() != 0 || in_valid) @(posedge clk);
    while (pending_codes.size() != 0) @(posedge clk);
    // let anything still in the chain come out
    repeat (LATENCY + 16) @(posedge clk);

    if (pending_codes.size() != 0) begin
      $error("code: %0d expected codes never arrived", pending_codes.size());
      fails++;
    end
    $display("%0d bytes in %0d blocks sent, %0d codes checked, %0d mismatches",
             beats_sent, blocks_n, codes_checked, fails);
    $display("covered: dropped bytes, zero-start swap, full alphabet block, hold-off %0d, drain %0d",
             hold_done, drain_done);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
